@@ hw/rtl/sma_pkg.sv @@
// shared types and constants for the sign-magnitude alu
package sma_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIV0 = 2'd2,
      ST_BIG  = 2'd3
   } status_type;

endpackage

@@ hw/rtl/sign_magnitude_alu.sv @@
// sign-magnitude alu top level: add/sub front end, cell chain, output skid
// pipeline: front register, WORD_BITS-1 chain cells and one output register
// throughput: one transaction per cycle while the output skid has room; each cell does one multiply and one divide bit
// the chain advances only while the output skid has room; req_tready follows that
// reset clears valid bits of the chain and the output stage; data registers are not reset
module sign_magnitude_alu #(
   parameter int WORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], a_sign, a_magnitude, b_sign, b_magnitude, zero pad
   input  logic [((2*WORD_BITS+2+7)/8)*8-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_sign, result_magnitude, remainder_sign, remainder_magnitude, status, zero pad
   output logic [((3*WORD_BITS+3+7)/8)*8-1:0] rsp_tdata
);

   localparam int M      = WORD_BITS - 1;
   localparam int OUT_W  = ((3*WORD_BITS+3+7)/8)*8;
   localparam int PAY_W  = 3*WORD_BITS + 1;

   logic [1:0]   op;
   logic         as_w, bs_w;
   logic [M-1:0] am_w, bm_w;
   logic         space, adv;

   assign op   = req_tdata[1:0];
   assign as_w = req_tdata[2];
   assign am_w = req_tdata[3 +: M];
   assign bs_w = req_tdata[3+M];
   assign bm_w = req_tdata[4+M +: M];

   // chain stalls as a whole; skid absorbs the in-flight transaction
   assign adv        = space;
   assign req_tready = space;

   // add / subtract front end
   logic          eb, same;
   logic [M:0]    sum_full;
   logic [2*M-1:0] s_mag;
   logic          s_sign;
   logic [1:0]    s_stat;

   always_comb begin
      eb       = bs_w ^ (op == sma_pkg::OP_SUB);
      same     = (as_w == eb);
      sum_full = {1'b0, am_w} + {1'b0, bm_w};
      s_stat   = sma_pkg::ST_OK;
      s_sign   = 1'b0;
      s_mag    = '0;
      if (same) begin
         s_mag  = {{M{1'b0}}, sum_full[M-1:0]};
         s_sign = as_w;
         if (sum_full[M]) begin
            s_stat = sma_pkg::ST_OVF;
         end
      end else if (am_w > bm_w) begin
         s_mag  = {{M{1'b0}}, am_w - bm_w};
         s_sign = as_w;
      end else begin
         s_mag  = {{M{1'b0}}, bm_w - am_w};
         s_sign = eb;
      end
   end

   // chain wires, index 0 is the front register
   logic           c_valid  [0:M];
   logic           c_is_div [0:M];
   logic [2*M-1:0] c_acc    [0:M];
   logic [M-1:0]   c_a      [0:M];
   logic [M-1:0]   c_b      [0:M];
   logic [M-1:0]   c_quo    [0:M];
   logic [M:0]     c_rem    [0:M];
   logic           c_as     [0:M];
   logic           c_bs     [0:M];
   logic [1:0]     c_st     [0:M];
   logic [2*M-1:0] c_sum    [0:M];
   logic           c_ss     [0:M];

   logic           f_valid_ff, f_div_ff, f_as_ff, f_bs_ff, f_ss_ff;
   logic [M-1:0]   f_a_ff, f_b_ff;
   logic [1:0]     f_st_ff, f_st_in;
   logic [2*M-1:0] f_sum_ff;

   always_comb begin
      f_st_in = s_stat;
      if (op == sma_pkg::OP_MUL) begin
         f_st_in = sma_pkg::ST_OK;
      end else if (op == sma_pkg::OP_DIV) begin
         if (bm_w == '0) begin
            f_st_in = sma_pkg::ST_DIV0;
         end else if (bm_w > am_w) begin
            f_st_in = sma_pkg::ST_BIG;
         end else begin
            f_st_in = sma_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= req_tvalid;
      end
      if (adv) begin
         f_div_ff <= (op == sma_pkg::OP_DIV);
         f_a_ff   <= am_w;
         // add and subtract carry a zero multiplier so the product stays clear
         f_b_ff   <= (op == sma_pkg::OP_MUL || op == sma_pkg::OP_DIV) ? bm_w : '0;
         f_as_ff  <= as_w;
         f_bs_ff  <= bs_w;
         f_st_ff  <= f_st_in;
         f_sum_ff <= (op == sma_pkg::OP_MUL || op == sma_pkg::OP_DIV) ? '0 : s_mag;
         f_ss_ff  <= s_sign;
      end
   end

   assign c_valid[0]  = f_valid_ff;
   assign c_is_div[0] = f_div_ff;
   assign c_acc[0]    = '0;
   assign c_a[0]      = f_a_ff;
   assign c_b[0]      = f_b_ff;
   assign c_quo[0]    = '0;
   assign c_rem[0]    = '0;
   assign c_as[0]     = f_as_ff;
   assign c_bs[0]     = f_bs_ff;
   assign c_st[0]     = f_st_ff;
   assign c_sum[0]    = f_sum_ff;
   assign c_ss[0]     = f_ss_ff;

   // every cell holds its contents while the output skid is full
   for (genvar i = 0; i < M; i++) begin : g_chain
      sma_cell #(.MAG_BITS(M), .STEP(i)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (adv),
         .up_valid    (c_valid[i]),
         .up_is_div   (c_is_div[i]),
         .up_acc      (c_acc[i]),
         .up_a        (c_a[i]),
         .up_b        (c_b[i]),
         .up_quo      (c_quo[i]),
         .up_rem      (c_rem[i]),
         .up_a_sign   (c_as[i]),
         .up_b_sign   (c_bs[i]),
         .up_status   (c_st[i]),
         .up_sum      (c_sum[i]),
         .up_sum_sign (c_ss[i]),
         .dn_valid    (c_valid[i+1]),
         .dn_is_div   (c_is_div[i+1]),
         .dn_acc      (c_acc[i+1]),
         .dn_a        (c_a[i+1]),
         .dn_b        (c_b[i+1]),
         .dn_quo      (c_quo[i+1]),
         .dn_rem      (c_rem[i+1]),
         .dn_a_sign   (c_as[i+1]),
         .dn_b_sign   (c_bs[i+1]),
         .dn_status   (c_st[i+1]),
         .dn_sum      (c_sum[i+1]),
         .dn_sum_sign (c_ss[i+1])
      );
   end

   // final assembly of the result fields
   logic [1:0]     op_st;
   logic           r_sign, q_sign;
   logic [2*M-1:0] r_mag;
   logic [M-1:0]   q_mag;
   logic [PAY_W-1:0] pay;

   always_comb begin
      op_st  = c_st[M];
      r_mag  = c_sum[M];
      r_sign = c_ss[M];
      q_mag  = '0;
      q_sign = 1'b0;
      if (c_is_div[M]) begin
         r_mag  = '0;
         r_sign = 1'b0;
         if (op_st == sma_pkg::ST_OK) begin
            r_mag  = {{M{1'b0}}, c_quo[M]};
            r_sign = c_as[M] ^ c_bs[M];
            q_mag  = c_rem[M][M-1:0];
            q_sign = c_as[M];
         end else if (op_st == sma_pkg::ST_BIG) begin
            q_mag  = c_a[M];
            q_sign = c_as[M];
         end
      end else if (c_sum[M] == '0 && c_st[M] == sma_pkg::ST_OK && c_acc[M] != '0) begin
         r_mag  = c_acc[M];
         r_sign = c_as[M] ^ c_bs[M];
      end
      if (r_mag == '0) begin
         r_sign = 1'b0;
      end
      if (q_mag == '0) begin
         q_sign = 1'b0;
      end
      pay = {op_st, q_mag, q_sign, r_mag, r_sign};
   end

   // a valid leaving the chain while the skid is full cannot occur: adv gates entry
   logic [OUT_W-1:0] out_w;

   sma_out #(.W(OUT_W)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid[M] && adv),
      .in_data   ({{(OUT_W-PAY_W){1'b0}}, pay}),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_w)
   );

   assign rsp_tdata = out_w;

endmodule

@@ hw/rtl/sma_cell.sv @@
// one cell of the chain: a multiply step and a restoring divide step per cycle while enabled
module sma_cell #(
   parameter int MAG_BITS = 15,
   parameter int STEP     = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    up_valid,
   input  logic                    up_is_div,
   input  logic [2*MAG_BITS-1:0]   up_acc,
   input  logic [MAG_BITS-1:0]     up_a,
   input  logic [MAG_BITS-1:0]     up_b,
   input  logic [MAG_BITS-1:0]     up_quo,
   input  logic [MAG_BITS:0]       up_rem,
   input  logic                    up_a_sign,
   input  logic                    up_b_sign,
   input  logic [1:0]              up_status,
   input  logic [2*MAG_BITS-1:0]   up_sum,
   input  logic                    up_sum_sign,
   output logic                    dn_valid,
   output logic                    dn_is_div,
   output logic [2*MAG_BITS-1:0]   dn_acc,
   output logic [MAG_BITS-1:0]     dn_a,
   output logic [MAG_BITS-1:0]     dn_b,
   output logic [MAG_BITS-1:0]     dn_quo,
   output logic [MAG_BITS:0]       dn_rem,
   output logic                    dn_a_sign,
   output logic                    dn_b_sign,
   output logic [1:0]              dn_status,
   output logic [2*MAG_BITS-1:0]   dn_sum,
   output logic                    dn_sum_sign
);

   localparam int BIT = MAG_BITS - 1 - STEP;

   logic                  valid_ff;
   logic [2*MAG_BITS-1:0] acc_in, acc_ff;
   logic [MAG_BITS-1:0]   quo_in, quo_ff;
   logic [MAG_BITS:0]     rem_in, rem_ff;
   logic [MAG_BITS:0]     shifted;
   logic [MAG_BITS:0]     trial;
   logic                  is_div_ff, a_sign_ff, b_sign_ff, sum_sign_ff;
   logic [MAG_BITS-1:0]   a_ff, b_ff;
   logic [1:0]            status_ff;
   logic [2*MAG_BITS-1:0] sum_ff;

   always_comb begin
      // multiply: add the shifted multiplicand where this multiplier bit is set
      acc_in = up_acc;
      if (up_b[STEP]) begin
         acc_in = up_acc + ({{MAG_BITS{1'b0}}, up_a} << STEP);
      end
      // divide: bring in the next dividend bit, subtract when it fits
      shifted = {up_rem[MAG_BITS-1:0], up_a[BIT]};
      trial   = shifted - {1'b0, up_b};
      quo_in  = up_quo;
      rem_in  = shifted;
      if (shifted >= {1'b0, up_b}) begin
         quo_in[BIT] = 1'b1;
         rem_in      = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
      if (enable) begin
         acc_ff      <= acc_in;
         quo_ff      <= quo_in;
         rem_ff      <= rem_in;
         is_div_ff   <= up_is_div;
         a_ff        <= up_a;
         b_ff        <= up_b;
         a_sign_ff   <= up_a_sign;
         b_sign_ff   <= up_b_sign;
         status_ff   <= up_status;
         sum_ff      <= up_sum;
         sum_sign_ff <= up_sum_sign;
      end
   end

   assign dn_valid    = valid_ff;
   assign dn_is_div   = is_div_ff;
   assign dn_acc      = acc_ff;
   assign dn_a        = a_ff;
   assign dn_b        = b_ff;
   assign dn_quo      = quo_ff;
   assign dn_rem      = rem_ff;
   assign dn_a_sign   = a_sign_ff;
   assign dn_b_sign   = b_sign_ff;
   assign dn_status   = status_ff;
   assign dn_sum      = sum_ff;
   assign dn_sum_sign = sum_sign_ff;

endmodule

@@ hw/rtl/sma_out.sv @@
// output stage: skid buffer holding up to two finished transactions
module sma_out #(
   parameter int W = 49
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  logic [W-1:0] in_data,
   output logic         space,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic [W-1:0] main_ff, skid_ff;
   logic         main_v_ff, skid_v_ff;

   // accept while the skid slot is free; pipeline holds when both are full
   assign space     = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!main_v_ff || out_ready) begin
            if (skid_v_ff) begin
               main_ff   <= skid_ff;
               main_v_ff <= 1'b1;
               skid_v_ff <= 1'b0;
               if (in_valid) begin
                  skid_ff   <= in_data;
                  skid_v_ff <= 1'b1;
               end
            end else begin
               main_ff   <= in_data;
               main_v_ff <= in_valid;
            end
         end else if (in_valid) begin
            skid_ff   <= in_data;
            skid_v_ff <= 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) skid_v_ff |-> main_v_ff)
      else $error("skid slot full while main slot empty");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("stalled result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !out_ready) |=> skid_v_ff)
      else $error("skid content lost under stall");

endmodule

@@ test/sign_magnitude_alu_tb.sv @@
// self-checking testbench for the sign-magnitude alu: directed and random operand streams
module sign_magnitude_alu_tb;

   localparam int WB = 16;
   localparam int MB = WB - 1;
   localparam int REQ_W = ((2*WB+2+7)/8)*8;
   localparam int RSP_W = ((3*WB+3+7)/8)*8;
   localparam int N_RANDOM = 1700;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic       result_sign;
      logic [2*MB-1:0] result_magnitude;
      logic       remainder_sign;
      logic [MB-1:0] remainder_magnitude;
      sma_pkg::status_type status;
   } alu_result_type;

   class alu_scoreboard;
      alu_result_type pending[$];
      int checked;

      function alu_result_type compute(sma_pkg::op_type op, logic as, logic [MB-1:0] am,
                                       logic bs, logic [MB-1:0] bm);
         alu_result_type r;
         logic eb;
         logic [MB:0] sum;
         r = '0;
         r.status = sma_pkg::ST_OK;
         case (op)
            sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
               eb = bs ^ (op == sma_pkg::OP_SUB);
               if (as == eb) begin
                  sum = {1'b0, am} + {1'b0, bm};
                  r.result_sign = as;
                  r.result_magnitude = {{MB{1'b0}}, sum[MB-1:0]};
                  if (sum[MB]) r.status = sma_pkg::ST_OVF;
               end else if (am > bm) begin
                  r.result_sign = as;
                  r.result_magnitude = {{MB{1'b0}}, am - bm};
               end else if (bm > am) begin
                  r.result_sign = eb;
                  r.result_magnitude = {{MB{1'b0}}, bm - am};
               end
            end
            sma_pkg::OP_MUL: begin
               r.result_sign = as ^ bs;
               r.result_magnitude = {{MB{1'b0}}, am} * {{MB{1'b0}}, bm};
            end
            default: begin
               if (bm == 0) r.status = sma_pkg::ST_DIV0;
               else if (bm > am) begin
                  r.status = sma_pkg::ST_BIG;
                  r.remainder_sign = as;
                  r.remainder_magnitude = am;
               end else begin
                  r.result_sign = as ^ bs;
                  r.result_magnitude = {{MB{1'b0}}, am / bm};
                  r.remainder_sign = as;
                  r.remainder_magnitude = am % bm;
               end
            end
         endcase
         // zero is always positive
         if (r.result_magnitude == 0) r.result_sign = 1'b0;
         if (r.remainder_magnitude == 0) r.remainder_sign = 1'b0;
         return r;
      endfunction

      function void note_request(logic [REQ_W-1:0] d);
         pending.push_back(compute(sma_pkg::op_type'(d[1:0]), d[2], d[3+:MB], d[3+MB],
                                   d[4+MB+:MB]));
      endfunction

      function void check_response(logic [RSP_W-1:0] d, output string msg);
         alu_result_type e;
         logic [2*MB-1:0] rm;
         logic [MB-1:0] qm;
         msg = "";
         checked++;
         rm = d[1+:2*MB];
         qm = d[2+2*MB+:MB];
         if (pending.size() == 0) begin
            msg = "response with no request outstanding";
            return;
         end
         e = pending.pop_front();
         if (d[0] !== e.result_sign || rm !== e.result_magnitude ||
             d[1+2*MB] !== e.remainder_sign || qm !== e.remainder_magnitude ||
             d[2+3*MB+:2] !== e.status)
            $sformat(msg, "got s%0d m%0d rs%0d rm%0d st%0d, want s%0d m%0d rs%0d rm%0d st%0d",
                     d[0], rm, d[1+2*MB], qm, d[2+3*MB+:2], e.result_sign,
                     e.result_magnitude, e.remainder_sign, e.remainder_magnitude, e.status);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   alu_scoreboard sb;
   int errors = 0;
   int idle_pct = 36;
   bit hold_rsp = 0;
   int quiet_cycles = 0;
   int sent = 0;

   sign_magnitude_alu #(.WORD_BITS(WB)) dut (.*);

   always #1 clock = ~clock;

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   // offers one transaction, with a random gap first, and waits for acceptance
   task automatic send(sma_pkg::op_type op, logic as, logic [MB-1:0] am, logic bs,
                       logic [MB-1:0] bm);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W-2*WB-2){1'b0}}, bm, bs, am, as, op};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_random();
      logic [MB-1:0] am, bm;
      case ($urandom_range(3))
         0: am = MB'($urandom);
         1: am = MB'($urandom_range(15));
         2: am = MB'({MB{1'b1}} - $urandom_range(3));
         default: am = MB'($urandom_range(300));
      endcase
      bm = ($urandom_range(3) == 0) ? am : (($urandom_range(4) == 0) ?
                                            MB'($urandom_range(15)) : MB'($urandom));
      send(sma_pkg::op_type'($urandom_range(3)), 1'($urandom), am, 1'($urandom), bm);
   endtask

   // stops offering and waits until every accepted transaction has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata, msg);
            if (msg != "") report(msg);
         end
         quiet_cycles = ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ?
                        0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d responses outstanding", sb.pending.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // receiver readiness
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_rsp && ($urandom_range(99) >= idle_pct);
   end

   initial begin
      logic [MB-1:0] mx;
      int hold;
      sb = new();
      mx = {MB{1'b1}};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, overflow, equal magnitudes, negative zero
      send(sma_pkg::OP_ADD, 1'b0, mx, 1'b0, mx);
      send(sma_pkg::OP_ADD, 1'b1, mx, 1'b1, 15'd1);
      send(sma_pkg::OP_ADD, 1'b1, 15'd16384, 1'b1, 15'd16384);
      send(sma_pkg::OP_ADD, 1'b0, 15'd5, 1'b1, 15'd5);
      send(sma_pkg::OP_ADD, 1'b1, 15'd0, 1'b1, 15'd0);
      send(sma_pkg::OP_ADD, 1'b1, 15'd3, 1'b0, 15'd9);
      send(sma_pkg::OP_SUB, 1'b0, 15'd7, 1'b0, 15'd7);
      send(sma_pkg::OP_SUB, 1'b0, 15'd0, 1'b1, mx);
      send(sma_pkg::OP_SUB, 1'b1, 15'd2, 1'b0, mx);
      send(sma_pkg::OP_SUB, 1'b1, 15'd9, 1'b1, 15'd4);
      send(sma_pkg::OP_MUL, 1'b0, mx, 1'b1, mx);
      send(sma_pkg::OP_MUL, 1'b1, 15'd0, 1'b0, 15'd123);
      send(sma_pkg::OP_MUL, 1'b1, mx, 1'b1, 15'd1);
      send(sma_pkg::OP_DIV, 1'b1, 15'd100, 1'b0, 15'd0);
      send(sma_pkg::OP_DIV, 1'b0, 15'd0, 1'b0, 15'd0);
      send(sma_pkg::OP_DIV, 1'b1, 15'd5, 1'b0, 15'd9);
      send(sma_pkg::OP_DIV, 1'b0, 15'd0, 1'b1, 15'd3);
      send(sma_pkg::OP_DIV, 1'b1, mx, 1'b0, 15'd1);
      send(sma_pkg::OP_DIV, 1'b1, 15'd100, 1'b1, 15'd10);
      send(sma_pkg::OP_DIV, 1'b0, mx, 1'b1, mx);
      send(sma_pkg::OP_DIV, 1'b1, 15'd1000, 1'b0, 15'd7);
      drain();

      // receiver holds off while the sender keeps offering
      hold_rsp = 1;
      fork
         begin
            hold = 0;
            while (hold < 80) begin @(posedge clock); hold++; end
            hold_rsp = 0;
         end
         repeat (40) send_random();
      join
      drain();

      for (int i = 0; i < N_RANDOM; i++) begin
         idle_pct = (i >= 600 && i < 900) ? 0 : 36;
         send_random();
         if (i == 1200) drain();
      end
      idle_pct = 36;
      drain();
      repeat (3*WB) @(posedge clock);
      $display("sent %0d operand pairs across all four operations, %0d responses checked",
               sent, sb.checked);
      if (errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
